FILE: rtl/rsat_pkg.sv
// ----------------------------------------------------------------------------
// rsat_pkg
// Shared types and constants of the range assign / range sum table.
// ----------------------------------------------------------------------------
package rsat_pkg;

    localparam int TABLE_SIZE_DEF = 1024;
    localparam int IN_IDX_W       = 10;
    localparam int VAL_W          = 32;
    localparam int SUM_W          = 42;
    localparam int CALC_W         = 18;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ASSIGN,
        ST_SUM,
        ST_DRAIN,
        ST_FINISH,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic write_zero;
        logic write_value;
        logic read;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic empty;
        logic last_range;
        logic last_index;
    } sts_t;

endpackage

FILE: rtl/rsat_ctrl.sv
// ----------------------------------------------------------------------------
// rsat_ctrl
// Sequencer for table clearing, range assign and range sum sweeps.
// ----------------------------------------------------------------------------
module rsat_ctrl
    import rsat_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.last_index)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.empty)
                begin
                    state_next = sts.is_query ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    state_next = sts.is_query ? ST_SUM : ST_ASSIGN;
                end
            end
            ST_ASSIGN:
            begin
                if (sts.last_range)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                if (sts.last_range)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.write_zero = 1'b1;
                cmd.step       = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_ASSIGN:
            begin
                cmd.write_value = 1'b1;
                cmd.step        = 1'b1;
            end
            ST_SUM:
            begin
                cmd.read = 1'b1;
                cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = 1'b1;
            end
            ST_RESULT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/rsat_dp.sv
// ----------------------------------------------------------------------------
// rsat_dp
// Table memory, index counter, accumulator and result register.
// ----------------------------------------------------------------------------
module rsat_dp
    import rsat_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                operation,
    input  logic [IN_IDX_W-1:0] range_low,
    input  logic [IN_IDX_W-1:0] range_high,
    input  logic [VAL_W-1:0]    value,
    output logic [SUM_W-1:0]    range_sum,
    input  cmd_t                cmd,
    output sts_t                sts
);

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int ACC_W = VAL_W + IDX_W;
    localparam int SAT_W = (ACC_W > SUM_W) ? ACC_W : SUM_W;
    localparam logic [CALC_W-1:0] LAST_IDX = CALC_W'(TABLE_SIZE - 1);
    localparam logic [SAT_W-1:0]  SUM_MAX  = SAT_W'({SUM_W{1'b1}});

    logic [VAL_W-1:0] mem [TABLE_SIZE];

    logic             query_reg;
    logic             empty_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] high_reg;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [SUM_W-1:0] sum_reg;

    logic [CALC_W-1:0] low_ext;
    logic [CALC_W-1:0] high_ext;
    logic [CALC_W-1:0] high_clip;
    logic              empty_next;
    logic [SAT_W-1:0]  acc_ext;

    assign low_ext    = CALC_W'(range_low);
    assign high_ext   = CALC_W'(range_high);
    assign high_clip  = (high_ext > LAST_IDX) ? LAST_IDX : high_ext;
    assign empty_next = (low_ext > high_clip) || (low_ext > LAST_IDX);
    assign acc_ext    = SAT_W'(acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.read;
            if (cmd.load)
            begin
                cur_reg <= low_ext[IDX_W-1:0];
            end
            else if (cmd.step)
            begin
                cur_reg <= cur_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            query_reg <= operation;
            empty_reg <= empty_next;
            high_reg  <= high_clip[IDX_W-1:0];
            value_reg <= value;
        end
        if (cmd.write_zero)
        begin
            mem[cur_reg] <= '0;
        end
        else if (cmd.write_value)
        begin
            mem[cur_reg] <= value_reg;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[cur_reg];
        end
        if (cmd.load)
        begin
            acc_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(rd_data_reg);
        end
        if (cmd.out_load)
        begin
            sum_reg <= (acc_ext > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : acc_ext[SUM_W-1:0];
        end
    end

    assign range_sum      = sum_reg;
    assign sts.is_query   = query_reg;
    assign sts.empty      = empty_reg;
    assign sts.last_range = (cur_reg == high_reg);
    assign sts.last_index = (CALC_W'(cur_reg) == LAST_IDX);

endmodule

FILE: rtl/range_assign_range_sum_tree_top.sv
// ----------------------------------------------------------------------------
// range_assign_range_sum_tree_top
// Table of TABLE_SIZE values with range assign and range sum operations.
//
// An input transfer carries operation, range_low, range_high and value.
// An assign (operation 0) writes value to every index of the clipped range
// and returns nothing. A query (operation 1) returns one output transfer
// with range_sum, saturated to 42 bits, or zero for an empty range.
// The table memory has one port, so the indices of a range are visited one
// after another: an assign writes each of them, and a query reads each into
// the accumulator before its result is shown. Empty ranges skip this sweep.
// One item is in work at a time; in_ready is high only while idle.
// After reset a clearing pass writes zero to all TABLE_SIZE entries, one per
// cycle, and no input is taken during it. A stalled receiver holds the
// result on range_sum with out_valid high, and no new input is taken.
// ----------------------------------------------------------------------------
module range_assign_range_sum_tree_top
    import rsat_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic [IN_IDX_W-1:0] range_low,
    input  logic [IN_IDX_W-1:0] range_high,
    input  logic [VAL_W-1:0]    value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SUM_W-1:0]    range_sum
);

    cmd_t cmd;
    sts_t sts;

    rsat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rsat_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .operation  (operation),
        .range_low  (range_low),
        .range_high (range_high),
        .value      (value),
        .range_sum  (range_sum),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule
